[design/mfhb_pkg.sv]
// ----------------------------------------------------------------------------
// MAC frame header builder package
// Shared constants and types for the 802.15.4 MAC header builder.
// ----------------------------------------------------------------------------
`default_nettype none

package mfhb_pkg;

  // Header length with 2-byte addresses and an uncompressed source PAN.
  localparam logic [4:0] HDR_BASE     = 5'd11;
  // Extra bytes for an extended (8-byte) address.
  localparam logic [4:0] EXT_EXTRA    = 5'd6;
  // Bytes saved when the source PAN is left out.
  localparam logic [4:0] PAN_BYTES    = 5'd2;
  // Bytes before the destination address: frame control, sequence, PAN.
  localparam logic [4:0] FIXED_BYTES  = 5'd5;
  // Acknowledgement frame header length.
  localparam logic [4:0] ACK_LEN      = 5'd3;

  localparam logic [1:0] FRAME_VERSION = 2'b01;
  localparam logic [2:0] FC_TYPE_DATA  = 3'b001;
  localparam logic [7:0] ACK_FC        = 8'h02;
  localparam logic [1:0] MODE_EXT      = 2'd3;

  // Request as held while its header bytes go out.
  typedef struct packed {
    logic        ack_frame;
    logic        too_small;
    logic        compress;
    logic        dest_ext;
    logic [4:0]  count;
    logic [7:0]  frame_length;
    logic [15:0] fc;
    logic [7:0]  seq_number;
    logic [15:0] dest_pan;
    logic [63:0] dest_address;
    logic [15:0] src_pan;
    logic [63:0] src_address;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [7:0] header_byte;
    logic       byte_valid;
    logic       last;
    logic [7:0] frame_length;
    logic       too_small;
  } res_t;

endpackage

`default_nettype wire

[design/mfhb_byte_mux.sv]
// ----------------------------------------------------------------------------
// MAC frame header byte selector
// Picks the header byte at a given position of a stored request.
// ----------------------------------------------------------------------------
`default_nettype none

module mfhb_byte_mux (
  input  mfhb_pkg::req_t req,
  input  logic [4:0]     idx,
  output mfhb_pkg::res_t res
);

  logic [4:0] addr_pos;
  logic [4:0] dest_bytes;
  logic [4:0] tail_pos;
  logic [4:0] src_pos;
  logic [7:0] data_byte;

  // Position relative to the destination address and to what follows it.
  assign addr_pos   = idx - mfhb_pkg::FIXED_BYTES;
  assign dest_bytes = req.dest_ext ? 5'd8 : 5'd2;
  assign tail_pos   = addr_pos - dest_bytes;
  assign src_pos    = req.compress ? tail_pos : (tail_pos - mfhb_pkg::PAN_BYTES);

  // Data frame layout in transmit order, low byte first in each field.
  always_comb begin
    if (idx == 5'd0) begin
      data_byte = req.fc[7:0];
    end else if (idx == 5'd1) begin
      data_byte = req.fc[15:8];
    end else if (idx == 5'd2) begin
      data_byte = req.seq_number;
    end else if (idx == 5'd3) begin
      data_byte = req.dest_pan[7:0];
    end else if (idx == 5'd4) begin
      data_byte = req.dest_pan[15:8];
    end else if (addr_pos < dest_bytes) begin
      data_byte = req.dest_address[{addr_pos[2:0], 3'b000} +: 8];
    end else if (!req.compress && (tail_pos < mfhb_pkg::PAN_BYTES)) begin
      data_byte = tail_pos[0] ? req.src_pan[15:8] : req.src_pan[7:0];
    end else begin
      data_byte = req.src_address[{src_pos[2:0], 3'b000} +: 8];
    end
  end

  // Result fields for the selected position.
  always_comb begin
    res.frame_length = req.frame_length;
    res.too_small    = req.too_small;
    res.last         = (idx == (req.count - 5'd1));
    res.byte_valid   = !req.too_small;
    if (req.too_small) begin
      res.header_byte = 8'h00;
    end else if (req.ack_frame) begin
      case (idx)
        5'd0:    res.header_byte = mfhb_pkg::ACK_FC;
        5'd1:    res.header_byte = 8'h00;
        default: res.header_byte = req.seq_number;
      endcase
    end else begin
      res.header_byte = data_byte;
    end
  end

endmodule

`default_nettype wire

[design/mac_frame_header_builder_top.sv]
// ----------------------------------------------------------------------------
// MAC frame header builder
// Builds the 802.15.4 MAC header of a frame request, one byte per cycle.
// ----------------------------------------------------------------------------
// The request register takes the start transfer; the result register then strobes the first byte.
// Throughput: one header byte per cycle; a request gives N bytes, where N is
// 3 for an ack, 1 when the buffer is too small, else the header length (9..23).
// The next request is taken in the cycle that the last byte is selected.
// Reset (synchronous, active low) drops any request in flight and the strobe.
`default_nettype none

module mac_frame_header_builder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_cmd,
  input  wire logic        in_ack_request,
  input  wire logic [7:0]  in_seq_number,
  input  wire logic [15:0] in_dest_pan,
  input  wire logic [1:0]  in_dest_mode,
  input  wire logic [63:0] in_dest_address,
  input  wire logic [15:0] in_src_pan,
  input  wire logic [1:0]  in_src_mode,
  input  wire logic [63:0] in_src_address,
  input  wire logic [6:0]  in_payload_length,
  input  wire logic [7:0]  in_buffer_capacity,
  output logic             out_strobe,
  output logic [7:0]       out_header_byte,
  output logic             out_byte_valid,
  output logic             out_last,
  output logic [7:0]       out_frame_length,
  output logic             out_too_small
);

  mfhb_pkg::req_t req_r, req_nxt;
  mfhb_pkg::res_t res, res_r;
  logic           act_r;
  logic [4:0]     idx_r;
  logic           strobe_r;
  logic           accept;
  logic           dest_ext, src_ext, compress;
  logic [4:0]     hdr_len;
  logic [7:0]     flen;
  logic           over_cap;

  // Header length and capacity check for the incoming request.
  assign dest_ext = (in_dest_mode == mfhb_pkg::MODE_EXT);
  assign src_ext  = (in_src_mode == mfhb_pkg::MODE_EXT);
  assign compress = (in_src_pan == in_dest_pan);
  assign hdr_len  = mfhb_pkg::HDR_BASE
                  + (dest_ext ? mfhb_pkg::EXT_EXTRA : 5'd0)
                  + (src_ext ? mfhb_pkg::EXT_EXTRA : 5'd0)
                  - (compress ? mfhb_pkg::PAN_BYTES : 5'd0);
  assign flen     = in_cmd ? {3'b000, mfhb_pkg::ACK_LEN}
                           : ({3'b000, hdr_len} + {1'b0, in_payload_length});
  assign over_cap = !in_cmd && (in_buffer_capacity < flen);

  // Request fields captured at the start transfer.
  always_comb begin
    req_nxt.ack_frame    = in_cmd;
    req_nxt.too_small    = over_cap;
    req_nxt.compress     = compress;
    req_nxt.dest_ext     = dest_ext;
    req_nxt.count        = in_cmd ? mfhb_pkg::ACK_LEN : (over_cap ? 5'd1 : hdr_len);
    req_nxt.frame_length = flen;
    req_nxt.fc           = {in_src_mode, mfhb_pkg::FRAME_VERSION, in_dest_mode, 3'b000,
                            compress, in_ack_request, 2'b00, mfhb_pkg::FC_TYPE_DATA};
    req_nxt.seq_number   = in_seq_number;
    req_nxt.dest_pan     = in_dest_pan;
    req_nxt.dest_address = in_dest_address;
    req_nxt.src_pan      = in_src_pan;
    req_nxt.src_address  = in_src_address;
  end

  mfhb_byte_mux u_byte_mux (
    .req (req_r),
    .idx (idx_r),
    .res (res)
  );

  // Busy until the last byte of the current request is being selected.
  assign busy   = act_r && !res.last;
  assign accept = start && !busy;

  // Request register and byte position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      idx_r <= 5'd0;
    end else if (accept) begin
      act_r <= 1'b1;
      idx_r <= 5'd0;
    end else if (act_r) begin
      act_r <= !res.last;
      idx_r <= idx_r + 5'd1;
    end
    if (accept) begin
      req_r <= req_nxt;
    end
  end

  // Result register: one transfer per cycle, no backpressure.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= act_r;
    end
    res_r <= res;
  end

  assign out_strobe       = strobe_r;
  assign out_header_byte  = res_r.header_byte;
  assign out_byte_valid   = res_r.byte_valid;
  assign out_last         = res_r.last;
  assign out_frame_length = res_r.frame_length;
  assign out_too_small    = res_r.too_small;

  // A start transfer always opens a request.
  a_accept_active: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> act_r)
    else $error("request not active after start transfer");

  // A strobe only follows a cycle with an active request.
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(act_r))
    else $error("result strobe without an active request");

  // A too-small result is a lone, empty, final item.
  a_small_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_too_small) |-> (out_last && !out_byte_valid))
    else $error("too-small result is not a single empty item");

  // An empty byte only comes from a failed capacity check.
  a_valid_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_byte_valid) |-> out_too_small)
    else $error("empty byte without too-small flag");

endmodule

`default_nettype wire
